### rtl/pfpd_pkg.sv
// ----------------------------------------------------------------------------
// pfpd_pkg
// Types and constants shared by the plane-from-points-and-distance block.
// ----------------------------------------------------------------------------
package pfpd_pkg;

   localparam int CoordWidth = 32;
   localparam int OutWidth   = 32;

   // multiply-accumulate step indexes
   localparam logic [3:0] MAC_CROSS_FIRST = 4'd0;
   localparam logic [3:0] MAC_CROSS_LAST  = 4'd5;
   localparam logic [3:0] MAC_SQ_FIRST    = 4'd6;
   localparam logic [3:0] MAC_SQ_LAST     = 4'd8;
   localparam logic [3:0] MAC_DOT_FIRST   = 4'd9;
   localparam logic [3:0] MAC_DOT_LAST    = 4'd11;

   localparam logic [4:0] ITER_LAST = 5'd31;
   localparam logic [1:0] COMP_LAST = 2'd2;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DEGEN    = 2'd1,
      ST_NO_PLANE = 2'd2
   } stat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_EDGE,
      S_MUL,
      S_ACC,
      S_NORM,
      S_SQINIT,
      S_SQRT,
      S_DVINIT,
      S_DIV,
      S_DVEND,
      S_ROUND,
      S_DECIDE,
      S_FLIP,
      S_FIN
   } state_type;

   typedef struct packed {
      logic                         func;
      logic signed [CoordWidth-1:0] point_a_x;
      logic signed [CoordWidth-1:0] point_a_y;
      logic signed [CoordWidth-1:0] point_a_z;
      logic signed [CoordWidth-1:0] point_b_x;
      logic signed [CoordWidth-1:0] point_b_y;
      logic signed [CoordWidth-1:0] point_b_z;
      logic signed [CoordWidth-1:0] point_c_x;
      logic signed [CoordWidth-1:0] point_c_y;
      logic signed [CoordWidth-1:0] point_c_z;
   } req_type;

   typedef struct packed {
      logic signed [OutWidth-1:0] unit_normal_x;
      logic signed [OutWidth-1:0] unit_normal_y;
      logic signed [OutWidth-1:0] unit_normal_z;
      logic        [OutWidth-1:0] origin_distance;
      logic        [OutWidth-1:0] point_distance;
      logic        [1:0]          status;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       edge_en;
      logic       mul;
      logic       acc;
      logic [3:0] idx;
      logic       norm;
      logic       sq_init;
      logic       sq_step;
      logic       dv_init;
      logic       dv_step;
      logic       dv_end;
      logic [1:0] comp;
      logic       round;
      logic       flip;
      logic       fin;
      logic       degen;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic plane_valid;
      logic cr_zero;
      logic norm_done;
      logic dot_neg;
   } stat_bus_type;

endpackage

### rtl/pfpd_datapath.sv
// ----------------------------------------------------------------------------
// pfpd_datapath
// Edge vectors, shared multiplier and accumulator, normalizing shifter,
// bit-serial square root and divider, and the stored plane.
// ----------------------------------------------------------------------------
module pfpd_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  pfpd_pkg::req_type      req_data,
   input  pfpd_pkg::cmd_type      cmd,
   output pfpd_pkg::stat_bus_type st,
   output pfpd_pkg::rsp_type      rsp_data
);

   pfpd_pkg::req_type  req_ff;
   logic signed [32:0] e1_ff [3];
   logic signed [32:0] e2_ff [3];
   logic signed [65:0] prod_ff;
   logic signed [65:0] acc_ff;
   logic [61:0]        cr_mag_ff [3];
   logic               cr_neg_ff [3];
   logic [63:0]        sq_rad_ff;
   logic [35:0]        sq_rem_ff;
   logic [31:0]        sq_root_ff;
   logic [31:0]        dv_num_ff;
   logic [31:0]        dv_rem_ff;
   logic [31:0]        dv_q_ff;
   logic signed [31:0] n_ff [3];
   logic signed [35:0] dot_ff;
   logic signed [31:0] ns_ff [3];
   logic [31:0]        offset_ff;
   logic               pvalid_ff;
   pfpd_pkg::rsp_type  rsp_ff;

   logic signed [32:0] a_ext [3];
   logic signed [32:0] b_ext [3];
   logic signed [32:0] c_ext [3];
   logic signed [32:0] d1 [3];
   logic signed [32:0] d2 [3];
   logic [32:0]        m1 [3];
   logic [32:0]        m2 [3];
   logic [32:0]        e_or;
   logic [1:0]         e_shift;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] cr_diff;
   logic [61:0]        cr_abs;
   logic [61:0]        orv;
   logic               or_hi;
   logic [35:0]        sq_rem2;
   logic [35:0]        sq_trial;
   logic [61:0]        dv_n;
   logic [32:0]        dv_rem2;
   logic signed [65:0] acc_rnd;
   logic signed [36:0] meas_diff;
   logic [36:0]        meas_abs;
   logic [31:0]        meas_sat;
   logic [31:0]        d_sat;
   logic [31:0]        dv_sel_mag;

   always_comb begin
      a_ext[0] = {req_ff.point_a_x[31], req_ff.point_a_x};
      a_ext[1] = {req_ff.point_a_y[31], req_ff.point_a_y};
      a_ext[2] = {req_ff.point_a_z[31], req_ff.point_a_z};
      b_ext[0] = {req_ff.point_b_x[31], req_ff.point_b_x};
      b_ext[1] = {req_ff.point_b_y[31], req_ff.point_b_y};
      b_ext[2] = {req_ff.point_b_z[31], req_ff.point_b_z};
      c_ext[0] = {req_ff.point_c_x[31], req_ff.point_c_x};
      c_ext[1] = {req_ff.point_c_y[31], req_ff.point_c_y};
      c_ext[2] = {req_ff.point_c_z[31], req_ff.point_c_z};
      e_or = '0;
      for (int i = 0; i < 3; i++) begin
         d1[i] = b_ext[i] - a_ext[i];
         d2[i] = c_ext[i] - a_ext[i];
         m1[i] = d1[i][32] ? 33'(-d1[i]) : 33'(d1[i]);
         m2[i] = d2[i][32] ? 33'(-d2[i]) : 33'(d2[i]);
         e_or  = e_or | m1[i] | m2[i];
      end
      // or of the magnitudes has the same leading one as their maximum
      if (e_or[32]) begin
         e_shift = 2'd3;
      end else if (e_or[31]) begin
         e_shift = 2'd2;
      end else if (e_or[30]) begin
         e_shift = 2'd1;
      end else begin
         e_shift = 2'd0;
      end
   end

   always_comb begin
      case (cmd.idx)
         4'd0: begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         4'd1: begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         4'd2: begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         4'd3: begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         4'd4: begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         4'd5: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
         4'd6: begin
            mul_a = {1'b0, cr_mag_ff[0][31:0]};
            mul_b = {1'b0, cr_mag_ff[0][31:0]};
         end
         4'd7: begin
            mul_a = {1'b0, cr_mag_ff[1][31:0]};
            mul_b = {1'b0, cr_mag_ff[1][31:0]};
         end
         4'd8: begin
            mul_a = {1'b0, cr_mag_ff[2][31:0]};
            mul_b = {1'b0, cr_mag_ff[2][31:0]};
         end
         4'd9: begin
            mul_a = a_ext[0];
            mul_b = req_ff.func ? {ns_ff[0][31], ns_ff[0]} : {n_ff[0][31], n_ff[0]};
         end
         4'd10: begin
            mul_a = a_ext[1];
            mul_b = req_ff.func ? {ns_ff[1][31], ns_ff[1]} : {n_ff[1][31], n_ff[1]};
         end
         4'd11: begin
            mul_a = a_ext[2];
            mul_b = req_ff.func ? {ns_ff[2][31], ns_ff[2]} : {n_ff[2][31], n_ff[2]};
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      cr_diff  = acc_ff - prod_ff;
      cr_abs   = cr_diff[65] ? 62'(-cr_diff) : cr_diff[61:0];
      orv      = cr_mag_ff[0] | cr_mag_ff[1] | cr_mag_ff[2];
      or_hi    = |orv[61:31];
      sq_rem2  = {sq_rem_ff[33:0], sq_rad_ff[63:62]};
      sq_trial = {2'b00, sq_root_ff, 2'b01};
      case (cmd.comp)
         2'd0:    dv_sel_mag = cr_mag_ff[0][31:0];
         2'd1:    dv_sel_mag = cr_mag_ff[1][31:0];
         2'd2:    dv_sel_mag = cr_mag_ff[2][31:0];
         default: dv_sel_mag = '0;
      endcase
      dv_n     = {1'b0, dv_sel_mag[30:0], 30'd0} + 62'(sq_root_ff[31:1]);
      dv_rem2  = {dv_rem_ff, dv_num_ff[31]};
      acc_rnd  = acc_ff + 66'sd536870912;
      meas_diff = $signed({5'd0, offset_ff}) - 37'(dot_ff);
      meas_abs  = meas_diff[36] ? 37'(-meas_diff) : 37'(meas_diff);
      meas_sat  = (|meas_abs[36:32]) ? 32'hFFFF_FFFF : meas_abs[31:0];
      if (dot_ff[35]) begin
         d_sat = '0;
      end else if (|dot_ff[34:32]) begin
         d_sat = 32'hFFFF_FFFF;
      end else begin
         d_sat = dot_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.edge_en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= d1[i][32] ? -$signed(m1[i] >> e_shift) : $signed(m1[i] >> e_shift);
            e2_ff[i] <= d2[i][32] ? -$signed(m2[i] >> e_shift) : $signed(m2[i] >> e_shift);
         end
      end
      if (cmd.mul) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.acc) begin
         if (cmd.idx <= pfpd_pkg::MAC_CROSS_LAST) begin
            if (!cmd.idx[0]) begin
               acc_ff <= prod_ff;
            end else begin
               cr_mag_ff[cmd.idx[2:1]] <= cr_abs;
               cr_neg_ff[cmd.idx[2:1]] <= cr_diff[65];
            end
         end else if (cmd.idx == pfpd_pkg::MAC_SQ_FIRST ||
                      cmd.idx == pfpd_pkg::MAC_DOT_FIRST) begin
            acc_ff <= prod_ff;
         end else begin
            acc_ff <= acc_ff + prod_ff;
         end
      end
      if (cmd.norm && (orv != '0) && !(orv[30] && !or_hi)) begin
         for (int i = 0; i < 3; i++) begin
            cr_mag_ff[i] <= or_hi ? (cr_mag_ff[i] >> 1) : (cr_mag_ff[i] << 1);
         end
      end
      if (cmd.sq_init) begin
         sq_rad_ff  <= acc_ff[63:0];
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
      end
      if (cmd.sq_step) begin
         sq_rad_ff <= {sq_rad_ff[61:0], 2'b00};
         if (sq_rem2 >= sq_trial) begin
            sq_rem_ff  <= sq_rem2 - sq_trial;
            sq_root_ff <= {sq_root_ff[30:0], 1'b1};
         end else begin
            sq_rem_ff  <= sq_rem2;
            sq_root_ff <= {sq_root_ff[30:0], 1'b0};
         end
      end
      if (cmd.dv_init) begin
         dv_rem_ff <= {2'b00, dv_n[61:32]};
         dv_num_ff <= dv_n[31:0];
         dv_q_ff   <= '0;
      end
      if (cmd.dv_step) begin
         dv_num_ff <= {dv_num_ff[30:0], 1'b0};
         if (dv_rem2 >= {1'b0, sq_root_ff}) begin
            dv_rem_ff <= 32'(dv_rem2 - {1'b0, sq_root_ff});
            dv_q_ff   <= {dv_q_ff[30:0], 1'b1};
         end else begin
            dv_rem_ff <= dv_rem2[31:0];
            dv_q_ff   <= {dv_q_ff[30:0], 1'b0};
         end
      end
      if (cmd.dv_end) begin
         n_ff[cmd.comp] <= cr_neg_ff[cmd.comp] ? -$signed(dv_q_ff) : $signed(dv_q_ff);
      end
      if (cmd.round) begin
         dot_ff <= acc_rnd[65:30];
      end
      if (cmd.flip) begin
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= -n_ff[i];
         end
      end
      if (cmd.fin) begin
         rsp_ff.unit_normal_x   <= ns_ff[0];
         rsp_ff.unit_normal_y   <= ns_ff[1];
         rsp_ff.unit_normal_z   <= ns_ff[2];
         rsp_ff.origin_distance <= offset_ff;
         rsp_ff.point_distance  <= '0;
         if (req_ff.func) begin
            if (pvalid_ff) begin
               rsp_ff.point_distance <= meas_sat;
               rsp_ff.status         <= 2'(pfpd_pkg::ST_OK);
            end else begin
               rsp_ff.status <= 2'(pfpd_pkg::ST_NO_PLANE);
            end
         end else if (cmd.degen) begin
            rsp_ff.status <= 2'(pfpd_pkg::ST_DEGEN);
         end else begin
            rsp_ff.unit_normal_x   <= n_ff[0];
            rsp_ff.unit_normal_y   <= n_ff[1];
            rsp_ff.unit_normal_z   <= n_ff[2];
            rsp_ff.origin_distance <= d_sat;
            rsp_ff.status          <= 2'(pfpd_pkg::ST_OK);
         end
      end
   end

   // stored plane
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ns_ff[i] <= '0;
         end
         offset_ff <= '0;
         pvalid_ff <= 1'b0;
      end else if (cmd.fin && !req_ff.func && !cmd.degen) begin
         for (int i = 0; i < 3; i++) begin
            ns_ff[i] <= n_ff[i];
         end
         offset_ff <= d_sat;
         pvalid_ff <= 1'b1;
      end
   end

   assign st.func        = req_ff.func;
   assign st.plane_valid = pvalid_ff;
   assign st.cr_zero     = (orv == '0);
   assign st.norm_done   = orv[30] && !or_hi;
   assign st.dot_neg     = dot_ff[35];
   assign rsp_data       = rsp_ff;

endmodule

### rtl/pfpd_ctrl.sv
// ----------------------------------------------------------------------------
// pfpd_ctrl
// Sequencer for build and measure requests, and the result valid flag.
// ----------------------------------------------------------------------------
module pfpd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  pfpd_pkg::stat_bus_type st,
   output pfpd_pkg::cmd_type      cmd
);

   pfpd_pkg::state_type state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] comp_ff, comp_in;
   logic       degen_ff, degen_in;
   logic       flipped_ff, flipped_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfpd_pkg::S_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         degen_ff     <= 1'b0;
         flipped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         degen_ff     <= degen_in;
         flipped_ff   <= flipped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      degen_in     = degen_ff;
      flipped_in   = flipped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.idx      = idx_ff;
      cmd.comp     = comp_ff;
      cmd.degen    = degen_ff;
      req_ready    = 1'b0;
      case (state_ff)
         pfpd_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               degen_in   = 1'b0;
               flipped_in = 1'b0;
               state_in   = pfpd_pkg::S_DISPATCH;
            end
         end
         pfpd_pkg::S_DISPATCH: begin
            if (!st.func) begin
               state_in = pfpd_pkg::S_EDGE;
            end else if (st.plane_valid) begin
               idx_in   = pfpd_pkg::MAC_DOT_FIRST;
               state_in = pfpd_pkg::S_MUL;
            end else begin
               state_in = pfpd_pkg::S_FIN;
            end
         end
         pfpd_pkg::S_EDGE: begin
            cmd.edge_en = 1'b1;
            idx_in      = pfpd_pkg::MAC_CROSS_FIRST;
            state_in    = pfpd_pkg::S_MUL;
         end
         pfpd_pkg::S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = pfpd_pkg::S_ACC;
         end
         pfpd_pkg::S_ACC: begin
            cmd.acc = 1'b1;
            if (idx_ff == pfpd_pkg::MAC_CROSS_LAST) begin
               state_in = pfpd_pkg::S_NORM;
            end else if (idx_ff == pfpd_pkg::MAC_SQ_LAST) begin
               state_in = pfpd_pkg::S_SQINIT;
            end else if (idx_ff == pfpd_pkg::MAC_DOT_LAST) begin
               state_in = pfpd_pkg::S_ROUND;
            end else begin
               idx_in   = idx_ff + 4'd1;
               state_in = pfpd_pkg::S_MUL;
            end
         end
         pfpd_pkg::S_NORM: begin
            cmd.norm = 1'b1;
            if (st.cr_zero) begin
               degen_in = 1'b1;
               state_in = pfpd_pkg::S_FIN;
            end else if (st.norm_done) begin
               idx_in   = pfpd_pkg::MAC_SQ_FIRST;
               state_in = pfpd_pkg::S_MUL;
            end
         end
         pfpd_pkg::S_SQINIT: begin
            cmd.sq_init = 1'b1;
            cnt_in      = '0;
            state_in    = pfpd_pkg::S_SQRT;
         end
         pfpd_pkg::S_SQRT: begin
            cmd.sq_step = 1'b1;
            cnt_in      = cnt_ff + 5'd1;
            if (cnt_ff == pfpd_pkg::ITER_LAST) begin
               comp_in  = '0;
               state_in = pfpd_pkg::S_DVINIT;
            end
         end
         pfpd_pkg::S_DVINIT: begin
            cmd.dv_init = 1'b1;
            cnt_in      = '0;
            state_in    = pfpd_pkg::S_DIV;
         end
         pfpd_pkg::S_DIV: begin
            cmd.dv_step = 1'b1;
            cnt_in      = cnt_ff + 5'd1;
            if (cnt_ff == pfpd_pkg::ITER_LAST) begin
               state_in = pfpd_pkg::S_DVEND;
            end
         end
         pfpd_pkg::S_DVEND: begin
            cmd.dv_end = 1'b1;
            if (comp_ff == pfpd_pkg::COMP_LAST) begin
               idx_in   = pfpd_pkg::MAC_DOT_FIRST;
               state_in = pfpd_pkg::S_MUL;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = pfpd_pkg::S_DVINIT;
            end
         end
         pfpd_pkg::S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = pfpd_pkg::S_DECIDE;
         end
         pfpd_pkg::S_DECIDE: begin
            // negative offset on a build: flip the normal and redo the dot
            if (!st.func && st.dot_neg && !flipped_ff) begin
               state_in = pfpd_pkg::S_FLIP;
            end else begin
               state_in = pfpd_pkg::S_FIN;
            end
         end
         pfpd_pkg::S_FLIP: begin
            cmd.flip   = 1'b1;
            flipped_in = 1'b1;
            idx_in     = pfpd_pkg::MAC_DOT_FIRST;
            state_in   = pfpd_pkg::S_MUL;
         end
         pfpd_pkg::S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.fin      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pfpd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pfpd_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_fin_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> rsp_valid_ff)
      else $error("result not flagged after finish");

   a_sqrt_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == pfpd_pkg::S_SQINIT |=> (state_ff == pfpd_pkg::S_SQRT && cnt_ff == 5'd0))
      else $error("square root started with stale count");

   a_norm_before_sqrt: assert property (@(posedge clock) disable iff (reset)
      state_ff == pfpd_pkg::S_SQINIT |-> st.norm_done)
      else $error("cross product not normalized before square root");

endmodule

### rtl/plane_from_points_and_distance_top.sv
// build request: the path from acceptance to result includes a 32-step square root,
//   three 32-step divides and a normalize shift loop, and the dot is redone when the normal flips
// measure request: three multiplies from acceptance to result, none when no plane is stored
// one request in flight; next request taken while the result waits
// synchronous reset clears the stored plane to zero and marks no plane
// ----------------------------------------------------------------------------
// plane_from_points_and_distance_top
// Plane from three points with unit normal and offset; point-plane distance.
// ----------------------------------------------------------------------------
module plane_from_points_and_distance_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pfpd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pfpd_pkg::rsp_type rsp_data
);

   pfpd_pkg::cmd_type      cmd;
   pfpd_pkg::stat_bus_type st;

   pfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   pfpd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .st       (st),
      .rsp_data (rsp_data)
   );

endmodule
